[src/ppwi_pkg.sv]
// Shared constants and types for the pulse peak and window integral block.
package ppwi_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 16;
  localparam int INTEG_W     = 22;
  localparam int ACC_W       = SAMPLE_W + CNT_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_END     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SPAN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SPAN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_FALLBACK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_FALLBACK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EDGE     = 3'd6;

  localparam logic [6:0] RST_SEARCH_START   = 7'd20;
  localparam logic [6:0] RST_SEARCH_END     = 7'd50;
  localparam logic [6:0] RST_LEFT_SPAN      = 7'd4;
  localparam logic [6:0] RST_RIGHT_SPAN     = 7'd16;
  localparam logic [6:0] RST_LEFT_FALLBACK  = 7'd20;
  localparam logic [6:0] RST_RIGHT_FALLBACK = 7'd46;
  localparam logic [7:0] RST_RIGHT_EDGE     = 8'd60;

  localparam logic signed [ACC_W-1:0] INTEG_MAX = ACC_W'(2097151);
  localparam logic signed [ACC_W-1:0] INTEG_MIN = -ACC_W'(2097152);

  typedef struct packed {
    logic [6:0] search_start;
    logic [6:0] search_end;
    logic [6:0] left_span;
    logic [6:0] right_span;
    logic [6:0] left_fallback;
    logic [6:0] right_fallback;
    logic [7:0] right_edge;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
  } win_t;

endpackage

[src/pulse_peak_window_integral.sv]
// Top level: waveform capture, peak search and window integration.
// Samples are taken one per cycle while the block is capturing; each accepted sample, up to
// the 64 entries of the sample memory, is written there and, if it lies in the search range,
// compared against the running peak. After the sample flagged last, the block forms the
// window, then walks it through the memory read port at one entry per cycle, with the read
// data registered, and closes the walk once the last read has returned; it then posts the
// result when the output register is free. The result sits in an output register, so
// capture of the next waveform starts while it waits to be taken; a second finished result
// holds the input off until the first one is taken.
module pulse_peak_window_integral import ppwi_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_amplitude,
  output logic signed [INTEG_W-1:0]   out_integral,
  output logic [CNT_W-1:0]            out_peak_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam logic [1:0] ST_CAP  = 2'd0;
  localparam logic [1:0] ST_WIN  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                 state_r;
  cfg_t                       cfg_r;
  logic [CNT_W-1:0]           sample_count_r;
  logic [SAMPLE_W-1:0]        best_mag_r;
  logic [CNT_W-1:0]           best_index_r;
  logic signed [SAMPLE_W-1:0] best_value_r;
  logic [CNT_W-1:0]           rd_idx_r;
  logic [CNT_W-1:0]           hi_r;
  logic                       rd_vld_r;
  logic signed [SAMPLE_W-1:0] rd_q_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_amplitude_r;
  logic signed [INTEG_W-1:0]  out_integral_r;
  logic [CNT_W-1:0]           out_peak_index_r;

  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  logic                       in_req;
  logic                       wr_en;
  logic [CNT_W-1:0]           idx;
  logic [SAMPLE_W-1:0]        mag;
  logic                       better;
  logic                       rd_en;
  logic [CNT_W-1:0]           rd_addr;
  logic                       post;
  logic signed [INTEG_W-1:0]  integ_sat;
  win_t                       win;

  ppwi_window u_window (
    .cfg          (cfg_r),
    .peak_index   (best_index_r),
    .sample_count (sample_count_r),
    .win          (win)
  );

  assign in_ready  = (state_r == ST_CAP);
  assign cfg_ready = 1'b1;
  assign in_req    = in_valid && in_ready;
  assign wr_en     = in_req && (sample_count_r < CNT_W'(MAX_SAMPLES));
  assign idx       = sample_count_r + CNT_W'(1);
  assign mag       = in_sample[SAMPLE_W-1] ? (~in_sample + SAMPLE_W'(1)) : in_sample;
  assign better    = ({1'b0, idx} >= {1'b0, cfg_r.search_start}) &&
                     ({1'b0, idx} <= {1'b0, cfg_r.search_end}) && (mag > best_mag_r);
  assign rd_en     = (state_r == ST_SUM) && (rd_idx_r <= hi_r);
  assign rd_addr   = rd_idx_r - CNT_W'(1);
  assign post      = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    if (acc_r > INTEG_MAX) begin
      integ_sat = INTEG_MAX[INTEG_W-1:0];
    end else if (acc_r < INTEG_MIN) begin
      integ_sat = INTEG_MIN[INTEG_W-1:0];
    end else begin
      integ_sat = acc_r[INTEG_W-1:0];
    end
  end

  // writes only in capture, reads only in summing: no same-entry overlap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sample_count_r[ADDR_W-1:0]] <= in_sample;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.search_start   <= RST_SEARCH_START;
      cfg_r.search_end     <= RST_SEARCH_END;
      cfg_r.left_span      <= RST_LEFT_SPAN;
      cfg_r.right_span     <= RST_RIGHT_SPAN;
      cfg_r.left_fallback  <= RST_LEFT_FALLBACK;
      cfg_r.right_fallback <= RST_RIGHT_FALLBACK;
      cfg_r.right_edge     <= RST_RIGHT_EDGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEARCH_START:   cfg_r.search_start   <= cfg_data[6:0];
        CFG_SEARCH_END:     cfg_r.search_end     <= cfg_data[6:0];
        CFG_LEFT_SPAN:      cfg_r.left_span      <= cfg_data[6:0];
        CFG_RIGHT_SPAN:     cfg_r.right_span     <= cfg_data[6:0];
        CFG_LEFT_FALLBACK:  cfg_r.left_fallback  <= cfg_data[6:0];
        CFG_RIGHT_FALLBACK: cfg_r.right_fallback <= cfg_data[6:0];
        CFG_RIGHT_EDGE:     cfg_r.right_edge     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CAP;
      sample_count_r <= '0;
      best_mag_r     <= '0;
      best_index_r   <= '0;
      best_value_r   <= '0;
      rd_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= rd_en;
      case (state_r)
        ST_CAP: begin
          if (wr_en) begin
            sample_count_r <= idx;
            if (better) begin
              best_mag_r   <= mag;
              best_index_r <= idx;
              best_value_r <= in_sample;
            end
          end
          if (in_req && in_last) begin
            state_r <= ST_WIN;
          end
        end
        ST_WIN: begin
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (!rd_en && !rd_vld_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (post) begin
            sample_count_r <= '0;
            best_mag_r     <= '0;
            best_index_r   <= '0;
            best_value_r   <= '0;
            state_r        <= ST_CAP;
          end
        end
        default: state_r <= ST_CAP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WIN) begin
      rd_idx_r <= win.lo;
      hi_r     <= win.hi;
      acc_r    <= '0;
    end else begin
      if (rd_en) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      if (rd_vld_r) begin
        acc_r <= acc_r + ACC_W'(rd_q_r);
      end
    end
    if (post) begin
      out_amplitude_r  <= (best_index_r != '0) ? best_value_r : '0;
      out_integral_r   <= integ_sat;
      out_peak_index_r <= best_index_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_amplitude  = out_amplitude_r;
  assign out_integral   = out_integral_r;
  assign out_peak_index = out_peak_index_r;

  a_rd_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SUM))
    else $error("read data returned outside summing");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sample_count_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count past capacity");

  a_post_clears: assert property (@(posedge clk) disable iff (!rst_n)
    post |=> (out_valid_r && (sample_count_r == '0) && (state_r == ST_CAP)))
    else $error("result post did not clear waveform state");

  a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CAP) |=> $stable(sample_count_r) || $past(post))
    else $error("sample count changed outside capture");

endmodule

[src/ppwi_window.sv]
// Integration window bounds: span, fallbacks and clamping to received samples.
module ppwi_window import ppwi_pkg::*; (
  input  cfg_t             cfg,
  input  logic [CNT_W-1:0] peak_index,
  input  logic [CNT_W-1:0] sample_count,
  output win_t             win
);

  logic signed [CNT_W+1:0] lo_s;
  logic [CNT_W:0]          hi_s;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W:0]          hi;

  always_comb begin
    lo_s = $signed({2'b00, peak_index}) - $signed({2'b00, cfg.left_span});
    hi_s = {1'b0, peak_index} + {1'b0, cfg.right_span};
    if (lo_s <= 0) begin
      lo = cfg.left_fallback;
    end else begin
      lo = lo_s[CNT_W-1:0];
    end
    if (lo == '0) begin
      lo = CNT_W'(1);
    end
    if (hi_s >= cfg.right_edge) begin
      hi = {1'b0, cfg.right_fallback};
    end else begin
      hi = hi_s;
    end
    if (hi > {1'b0, sample_count}) begin
      hi = {1'b0, sample_count};
    end
    win.lo = lo;
    win.hi = hi[CNT_W-1:0];
  end

endmodule
